// ===== hdl/gfa_pkg.sv =====
// Shared types, opcodes and constant field tables for the GF(2^8) arithmetic unit.
// Tables are built at elaboration from the field multiply; no other dependencies.
package gfa_pkg;

    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_POW  = 3'd1,
        OP_LOG  = 3'd2,
        OP_INV  = 3'd3,
        OP_SBOX = 3'd4
    } gfa_op_t;

    localparam logic [7:0] GF_REDUCE  = 8'h1b;
    localparam logic [7:0] GF_GEN     = 8'h05;
    localparam logic [7:0] SBOX_CONST = 8'h63;
    localparam int         GROUP_ORD  = 255;

    typedef logic [255:0][7:0] byte_tbl_t;

    // partial product state of the shift-and-xor multiplier
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
    } gfa_mul_t;

    function automatic logic [7:0] gf_xtime(input logic [7:0] v);
        return v[7] ? ((v << 1) ^ GF_REDUCE) : (v << 1);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = '0;
        x   = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc = acc ^ x;
            x = gf_xtime(x);
        end
        return acc;
    endfunction

    function automatic byte_tbl_t build_exp_tbl();
        byte_tbl_t  t;
        logic [7:0] x;
        x = 8'h01;
        for (int e = 0; e < 256; e++) begin
            t[e] = x;
            x    = gf_mul(x, GF_GEN);
        end
        return t;
    endfunction

    // log(0) = 0, log(1) = 255
    function automatic byte_tbl_t build_log_tbl();
        byte_tbl_t  t;
        logic [7:0] x;
        t = '0;
        x = 8'h01;
        for (int e = 0; e < GROUP_ORD; e++) begin
            t[x] = (e == 0) ? 8'hff : 8'(e);
            x    = gf_mul(x, GF_GEN);
        end
        return t;
    endfunction

    // inv(0) = 0
    function automatic byte_tbl_t build_inv_tbl();
        byte_tbl_t t;
        byte_tbl_t ex;
        t  = '0;
        ex = build_exp_tbl();
        for (int e = 0; e < GROUP_ORD; e++) begin
            t[ex[e]] = ex[(GROUP_ORD - e) % GROUP_ORD];
        end
        return t;
    endfunction

    localparam byte_tbl_t EXP_TBL = build_exp_tbl();
    localparam byte_tbl_t LOG_TBL = build_log_tbl();
    localparam byte_tbl_t INV_TBL = build_inv_tbl();

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int s);
        return (v << s) | (v >> (8 - s));
    endfunction

    function automatic logic [7:0] sbox_affine(input logic [7:0] q);
        return q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4) ^ SBOX_CONST;
    endfunction

endpackage

// ===== hdl/gfa_mul_nibble.sv =====
// Four steps of the shift-and-xor GF(2^8) multiplier, one multiplier nibble.
// Depends on gfa_pkg for the partial product type and xtime.
module gfa_mul_nibble
    import gfa_pkg::*;
(
    input  gfa_mul_t   in_state,
    input  logic [3:0] y_nib,
    output gfa_mul_t   out_state
);

    always_comb begin
        gfa_mul_t st;
        st = in_state;
        for (int k = 0; k < 4; k++) begin
            if (y_nib[k]) st.acc = st.acc ^ st.x;
            st.x = gf_xtime(st.x);
        end
        out_state = st;
    end

endmodule

// ===== hdl/gf256_arith_unit.sv =====
// GF(2^8) arithmetic unit over 0x11B: mul, pow, log, inv and AES S-box.
// Depends on gfa_pkg (opcodes, tables, affine map) and gfa_mul_nibble.
//
//   channel | ports                      | contents
//   --------+----------------------------+-------------------------------------------
//   in      | s_tvalid s_tready s_tdata  | tdata[7:0] operand_a, [15:8] operand_b
//           | s_tuser                    | tuser[2:0] req_type
//   out     | m_tvalid m_tready m_tdata  | tdata[7:0] result
//
// One item per cycle when not stalled; items go through stages A, B and the output
// register. Stage A looks up the pow/log/inv tables and runs the low multiplier
// nibble, stage B the high nibble, the output stage applies the S-box affine map
// and selects the result. Each stage moves when it is empty or the next one moves,
// so bubbles close up under stall. Reset clears the valid bits only.
module gf256_arith_unit
    import gfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] operand_a, [15:8] operand_b
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] result
);

    typedef struct packed {
        logic [2:0] op;
        gfa_mul_t   mul;
        logic [3:0] y_hi;
        logic [7:0] tval;
    } stage_a_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] prod;
        logic [7:0] tval;
    } stage_b_t;

    logic       a_valid_reg, b_valid_reg, c_valid_reg;
    stage_a_t   a_reg, a_next;
    stage_b_t   b_reg, b_next;
    logic [7:0] c_reg, c_next;
    logic       en_a, en_b, en_c;
    gfa_mul_t   mul_init, mul_lo, mul_hi;
    logic [7:0] operand_a;

    assign operand_a = s_tdata[7:0];

    // acc starts at zero, x at operand_a
    assign mul_init = {8'h00, operand_a};

    assign en_c     = !c_valid_reg || m_tready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign s_tready = en_a;

    gfa_mul_nibble u_mul_lo (
        .in_state  (mul_init),
        .y_nib     (s_tdata[11:8]),
        .out_state (mul_lo)
    );

    always_comb begin
        a_next.op   = s_tuser;
        a_next.mul  = mul_lo;
        a_next.y_hi = s_tdata[15:12];
        case (s_tuser)
            OP_POW:          a_next.tval = EXP_TBL[operand_a];
            OP_LOG:          a_next.tval = LOG_TBL[operand_a];
            OP_INV, OP_SBOX: a_next.tval = INV_TBL[operand_a];
            default:         a_next.tval = 8'h00;
        endcase
    end

    gfa_mul_nibble u_mul_hi (
        .in_state  (a_reg.mul),
        .y_nib     (a_reg.y_hi),
        .out_state (mul_hi)
    );

    always_comb begin
        b_next.op   = a_reg.op;
        b_next.prod = mul_hi.acc;
        b_next.tval = a_reg.tval;
    end

    always_comb begin
        case (b_reg.op)
            OP_MUL:                  c_next = b_reg.prod;
            OP_POW, OP_LOG, OP_INV:  c_next = b_reg.tval;
            OP_SBOX:                 c_next = sbox_affine(b_reg.tval);
            default:                 c_next = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (en_a) a_valid_reg <= s_tvalid;
            if (en_b) b_valid_reg <= a_valid_reg;
            if (en_c) c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) a_reg <= a_next;
        if (en_b) b_reg <= b_next;
        if (en_c) c_reg <= c_next;
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = c_reg;

    // pipeline is empty right after reset
    assert property (@(posedge aclk) !aresetn |=> !a_valid_reg && !b_valid_reg && !m_tvalid)
        else $error("pipeline not flushed by reset");

    // a ready sink never back-pressures the source
    assert property (@(posedge aclk) disable iff (!aresetn) m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // a blocked stage A item keeps its contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !en_b |=> a_valid_reg && $stable(a_reg))
        else $error("stage A item lost under stall");

endmodule
